FILE: hdl/tli_pkg.sv
// tli_pkg: shared types, codes and reset values for the thermal load interlock.
// No dependencies; used by every module of the block.
package tli_pkg;

   localparam int TICK_WIDTH_DEF = 32;
   localparam int TEMP_WIDTH_DEF = 16;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int KIND_WIDTH = 3;

   localparam logic [KIND_WIDTH-1:0] KIND_IDLE      = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_HEATING   = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_COOL_SLOW = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_COOL_FAST = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_ALL_OFF   = 3'd4;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_ON_TICKS  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_OFF_TICKS = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEATER_OFFSET = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEATER_BAND   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEADROOM_ON   = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEADROOM_BAND = 3'd5;

   localparam logic [31:0]        RST_MIN_ON_TICKS  = 32'd60000;
   localparam logic [31:0]        RST_MIN_OFF_TICKS = 32'd180000;
   localparam logic signed [15:0] RST_HEATER_OFFSET = 16'sd160;
   localparam logic [14:0]        RST_HEATER_BAND   = 15'd16;
   localparam logic [15:0]        RST_HEADROOM_ON   = 16'd160;
   localparam logic [15:0]        RST_HEADROOM_BAND = 16'd32;

   typedef struct packed {
      logic [31:0]        min_on_ticks;
      logic [31:0]        min_off_ticks;
      logic signed [15:0] heater_offset;
      logic [14:0]        heater_band;
      logic [15:0]        headroom_on;
      logic [15:0]        headroom_band;
   } cfg_type;

   // per-mode control decoded from kind
   typedef struct packed {
      logic heat_eval;      // heater hysteresis evaluated, else cleared
      logic want;           // compressor requested
      logic cooling;        // cooling demand forces condenser fan
      logic ifan;           // internal fan
      logic headroom;       // condenser fan may follow headroom hysteresis
      logic headroom_clear; // headroom hysteresis forced off
   } mode_type;

   function automatic mode_type decode_kind(input logic [KIND_WIDTH-1:0] kind);
      mode_type m;
      m = '0;
      unique case (kind)
         KIND_IDLE: begin
            m.ifan = 1'b1;
            m.headroom = 1'b1;
         end
         KIND_HEATING: begin
            m.heat_eval = 1'b1;
            m.ifan = 1'b1;
            m.headroom = 1'b1;
         end
         KIND_COOL_SLOW: begin
            m.cooling = 1'b1;
            m.ifan = 1'b1;
         end
         KIND_COOL_FAST: begin
            m.want = 1'b1;
            m.cooling = 1'b1;
            m.ifan = 1'b1;
         end
         default: begin
            // all_off and unused codes
            m.headroom_clear = 1'b1;
         end
      endcase
      return m;
   endfunction

endpackage

FILE: hdl/tli_csr.sv
// tli_csr: configuration registers with write port and reset values.
// Depends on tli_pkg.
module tli_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [tli_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [tli_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   output tli_pkg::cfg_type                     cfg
);

   tli_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            tli_pkg::CSR_MIN_ON_TICKS:  cfg_in.min_on_ticks  = csr_data[31:0];
            tli_pkg::CSR_MIN_OFF_TICKS: cfg_in.min_off_ticks = csr_data[31:0];
            tli_pkg::CSR_HEATER_OFFSET: cfg_in.heater_offset = signed'(csr_data[15:0]);
            tli_pkg::CSR_HEATER_BAND:   cfg_in.heater_band   = csr_data[14:0];
            tli_pkg::CSR_HEADROOM_ON:   cfg_in.headroom_on   = csr_data[15:0];
            tli_pkg::CSR_HEADROOM_BAND: cfg_in.headroom_band = csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_on_ticks  <= tli_pkg::RST_MIN_ON_TICKS;
         cfg_ff.min_off_ticks <= tli_pkg::RST_MIN_OFF_TICKS;
         cfg_ff.heater_offset <= tli_pkg::RST_HEATER_OFFSET;
         cfg_ff.heater_band   <= tli_pkg::RST_HEATER_BAND;
         cfg_ff.headroom_on   <= tli_pkg::RST_HEADROOM_ON;
         cfg_ff.headroom_band <= tli_pkg::RST_HEADROOM_BAND;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hdl/tli_compressor.sv
// tli_compressor: compressor contactor with minimum on/off times, wrapping ticks.
// Depends on tli_pkg. Gives next state combinationally, commits it on step.
module tli_compressor #(
   parameter int TICK_WIDTH = tli_pkg::TICK_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  want,
   input  logic [TICK_WIDTH-1:0] now,
   input  tli_pkg::cfg_type      cfg,
   output logic                  running_next,
   output logic [TICK_WIDTH-1:0] on_since_next,
   output logic [TICK_WIDTH-1:0] off_since_next
);

   localparam int NowBits = (TICK_WIDTH < 32) ? TICK_WIDTH : 32;

   logic                  running_ff, running_in;
   logic [TICK_WIDTH-1:0] on_since_ff, on_since_in;
   logic [TICK_WIDTH-1:0] off_since_ff, off_since_in;
   logic [TICK_WIDTH-1:0] now_eff;
   logic [TICK_WIDTH-1:0] min_on, min_off;
   logic                  may_on, may_off;

   // tick time is at most 32 bits wide
   assign now_eff = TICK_WIDTH'(now[NowBits-1:0]);
   assign min_on  = TICK_WIDTH'(cfg.min_on_ticks);
   assign min_off = TICK_WIDTH'(cfg.min_off_ticks);

   // since == 0 means never: switch allowed at once
   assign may_on  = (off_since_ff == '0) || ((now_eff - off_since_ff) >= min_off);
   assign may_off = (on_since_ff == '0) || ((now_eff - on_since_ff) >= min_on);

   always_comb begin
      running_in   = running_ff;
      on_since_in  = on_since_ff;
      off_since_in = off_since_ff;
      if (want && !running_ff && may_on) begin
         running_in   = 1'b1;
         on_since_in  = now_eff;
         off_since_in = '0;
      end else if (!want && running_ff && may_off) begin
         running_in   = 1'b0;
         off_since_in = now_eff;
         on_since_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= 1'b0;
         on_since_ff  <= '0;
         off_since_ff <= '0;
      end else if (step) begin
         running_ff   <= running_in;
         on_since_ff  <= on_since_in;
         off_since_ff <= off_since_in;
      end
   end

   assign running_next   = running_in;
   assign on_since_next  = on_since_in;
   assign off_since_next = off_since_in;

endmodule

FILE: hdl/tli_loads.sv
// tli_loads: heater and condenser fan hysteresis with their state bits.
// Depends on tli_pkg; uses the compressor's next running state.
module tli_loads #(
   parameter int TEMP_WIDTH = tli_pkg::TEMP_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  tli_pkg::mode_type            mode,
   input  logic                         running,
   input  tli_pkg::cfg_type             cfg,
   input  logic signed [TEMP_WIDTH-1:0] air_setpoint,
   input  logic signed [TEMP_WIDTH-1:0] heater_temp,
   input  logic                         heater_temp_ok,
   input  logic signed [TEMP_WIDTH-1:0] comp_temp,
   input  logic                         comp_temp_ok,
   input  logic signed [TEMP_WIDTH-1:0] outside_temp,
   input  logic                         outside_temp_ok,
   output logic                         heater_drive,
   output logic                         condenser_fan_drive
);

   localparam int BaseW = (TEMP_WIDTH > 16) ? TEMP_WIDTH : 16;
   localparam int HeatW = BaseW + 3;
   localparam int RoomW = BaseW + 2;

   logic heater_hyst_ff, heater_hyst_in;
   logic headroom_hyst_ff, headroom_hyst_in;

   logic signed [HeatW-1:0] target, lo, hi, temp_h, band_h;
   logic signed [RoomW-1:0] delta, on_th, off_th, band_r;
   logic                    fan_forced;

   assign band_h = HeatW'(cfg.heater_band);
   assign target = HeatW'(air_setpoint) + HeatW'(cfg.heater_offset);
   assign lo     = target - band_h;
   assign hi     = target + band_h;
   assign temp_h = HeatW'(heater_temp);

   always_comb begin
      heater_hyst_in = 1'b0;
      if (mode.heat_eval && heater_temp_ok) begin
         if (heater_hyst_ff) begin
            heater_hyst_in = !(temp_h > hi);
         end else begin
            heater_hyst_in = temp_h < lo;
         end
      end
   end

   assign band_r = RoomW'(cfg.headroom_band);
   assign on_th  = RoomW'(cfg.headroom_on);
   assign off_th = on_th - band_r;
   assign delta  = RoomW'(comp_temp) - RoomW'(outside_temp);

   assign fan_forced = mode.cooling || running;

   // headroom state moves only when it decides the fan, or when it is forced off
   always_comb begin
      headroom_hyst_in = headroom_hyst_ff;
      if (mode.headroom_clear) begin
         headroom_hyst_in = 1'b0;
      end else if (mode.headroom && !fan_forced) begin
         if (!(comp_temp_ok && outside_temp_ok)) begin
            headroom_hyst_in = 1'b0;
         end else if (headroom_hyst_ff) begin
            headroom_hyst_in = !(delta < off_th);
         end else begin
            headroom_hyst_in = delta > on_th;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heater_hyst_ff   <= 1'b0;
         headroom_hyst_ff <= 1'b0;
      end else if (step) begin
         heater_hyst_ff   <= heater_hyst_in;
         headroom_hyst_ff <= headroom_hyst_in;
      end
   end

   assign heater_drive        = mode.heat_eval && heater_hyst_in && !running;
   assign condenser_fan_drive = fan_forced || (mode.headroom && headroom_hyst_in);

endmodule

FILE: hdl/thermal_load_interlock.sv
// thermal_load_interlock: top level. An accepted item passes the input register, then
// the result register, before it can be taken from rsp. Throughput one item per cycle
// while rsp_stall is low; the only feedback is the state committed on each step.
// While a result is held, the input register takes one more item, then req_stall rises.
// Synchronous active-high reset empties both stages, loads register defaults and clears
// compressor, since and hysteresis state.
module thermal_load_interlock #(
   parameter int TICK_WIDTH = tli_pkg::TICK_WIDTH_DEF,
   parameter int TEMP_WIDTH = tli_pkg::TEMP_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [tli_pkg::KIND_WIDTH-1:0]      req_kind,
   input  logic [TICK_WIDTH-1:0]               req_now_tick,
   input  logic signed [TEMP_WIDTH-1:0]        req_air_setpoint,
   input  logic signed [TEMP_WIDTH-1:0]        req_heater_temp,
   input  logic                                req_heater_temp_ok,
   input  logic signed [TEMP_WIDTH-1:0]        req_comp_temp,
   input  logic                                req_comp_temp_ok,
   input  logic signed [TEMP_WIDTH-1:0]        req_outside_temp,
   input  logic                                req_outside_temp_ok,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_heater_drive,
   output logic                                rsp_compressor_drive,
   output logic                                rsp_condenser_fan_drive,
   output logic                                rsp_chamber_fan_drive,
   output logic [TICK_WIDTH-1:0]               rsp_on_since_out,
   output logic [TICK_WIDTH-1:0]               rsp_off_since_out,
   input  logic                                csr_write,
   input  logic [tli_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tli_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   tli_pkg::cfg_type  cfg;
   tli_pkg::mode_type mode;

   logic in_valid_ff, in_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic advance, accept, step;

   logic [tli_pkg::KIND_WIDTH-1:0] kind_ff;
   logic [TICK_WIDTH-1:0]          now_ff;
   logic signed [TEMP_WIDTH-1:0]   sp_ff, ht_ff, ct_ff, at_ff;
   logic                           hok_ff, cok_ff, aok_ff;

   logic                  running_next;
   logic [TICK_WIDTH-1:0] on_since_next, off_since_next;
   logic                  heat_next, cond_next;

   logic                  heat_ff, comp_ff, cond_ff, ifan_ff;
   logic [TICK_WIDTH-1:0] on_ff, off_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign step      = in_valid_ff && advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind;
         now_ff  <= req_now_tick;
         sp_ff   <= req_air_setpoint;
         ht_ff   <= req_heater_temp;
         hok_ff  <= req_heater_temp_ok;
         ct_ff   <= req_comp_temp;
         cok_ff  <= req_comp_temp_ok;
         at_ff   <= req_outside_temp;
         aok_ff  <= req_outside_temp_ok;
      end
   end

   assign mode = tli_pkg::decode_kind(kind_ff);

   tli_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tli_compressor #(.TICK_WIDTH(TICK_WIDTH)) u_compressor (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .want           (mode.want),
      .now            (now_ff),
      .cfg            (cfg),
      .running_next   (running_next),
      .on_since_next  (on_since_next),
      .off_since_next (off_since_next)
   );

   tli_loads #(.TEMP_WIDTH(TEMP_WIDTH)) u_loads (
      .clock               (clock),
      .reset               (reset),
      .step                (step),
      .mode                (mode),
      .running             (running_next),
      .cfg                 (cfg),
      .air_setpoint        (sp_ff),
      .heater_temp         (ht_ff),
      .heater_temp_ok      (hok_ff),
      .comp_temp           (ct_ff),
      .comp_temp_ok        (cok_ff),
      .outside_temp        (at_ff),
      .outside_temp_ok     (aok_ff),
      .heater_drive        (heat_next),
      .condenser_fan_drive (cond_next)
   );

   always_ff @(posedge clock) begin
      if (step) begin
         heat_ff <= heat_next;
         comp_ff <= running_next;
         cond_ff <= cond_next;
         ifan_ff <= mode.ifan;
         on_ff   <= on_since_next;
         off_ff  <= off_since_next;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_heater_drive        = heat_ff;
   assign rsp_compressor_drive    = comp_ff;
   assign rsp_condenser_fan_drive = cond_ff;
   assign rsp_chamber_fan_drive   = ifan_ff;
   assign rsp_on_since_out        = on_ff;
   assign rsp_off_since_out       = off_ff;

endmodule

FILE: hdl/tli_checker.sv
// tli_checker: port-level assertions for thermal_load_interlock, bound to the top.
// Depends on tli_pkg for parameter defaults.
module tli_checker #(
   parameter int TICK_WIDTH = tli_pkg::TICK_WIDTH_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic                  rsp_heater_drive,
   input logic                  rsp_compressor_drive,
   input logic                  rsp_condenser_fan_drive,
   input logic                  rsp_chamber_fan_drive,
   input logic [TICK_WIDTH-1:0] rsp_on_since_out,
   input logic [TICK_WIDTH-1:0] rsp_off_since_out
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_heat_comp_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_heater_drive && rsp_compressor_drive))
      else $error("heater and compressor both on");

   a_comp_fan: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_compressor_drive) |-> rsp_condenser_fan_drive)
      else $error("compressor on without condenser fan");

   a_since_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_compressor_drive ? (rsp_off_since_out == '0)
                                          : (rsp_on_since_out == '0)))
      else $error("since value inconsistent with compressor state");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_heater_drive)
         && $stable(rsp_compressor_drive) && $stable(rsp_condenser_fan_drive)
         && $stable(rsp_chamber_fan_drive) && $stable(rsp_on_since_out)
         && $stable(rsp_off_since_out)))
      else $error("stalled item changed");

endmodule

bind thermal_load_interlock tli_checker #(.TICK_WIDTH(TICK_WIDTH)) u_tli_checker (
   .clock                   (clock),
   .reset                   (reset),
   .rsp_valid               (rsp_valid),
   .rsp_stall               (rsp_stall),
   .rsp_heater_drive        (rsp_heater_drive),
   .rsp_compressor_drive    (rsp_compressor_drive),
   .rsp_condenser_fan_drive (rsp_condenser_fan_drive),
   .rsp_chamber_fan_drive   (rsp_chamber_fan_drive),
   .rsp_on_since_out        (rsp_on_since_out),
   .rsp_off_since_out       (rsp_off_since_out)
);
